[sv/wslmm_pkg.sv]
// Shared types, constants and microcode encodings of the wheel speed loop and motor mix.
package wslmm_pkg;

	// Field widths
	localparam int BAL_W      = 24;
	localparam int DRV_W      = 25;
	localparam int CNT_W      = 16;
	localparam int TICK_W     = 5;
	localparam int ERR_W      = 13;
	localparam int ESUM_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int LIM_W      = 23;
	localparam int TGT_W      = 13;
	localparam int ELIM_W     = 12;
	localparam int GAIN_W     = 16;

	// Shared multiplier: unsigned gain or tick factor by a signed operand
	localparam int MA_W   = GAIN_W + 1;
	localparam int MB_W   = ESUM_W + 1;
	localparam int PROD_W = MA_W + MB_W;

	// Interpolation divider: radix-8 digits over the product magnitude
	localparam int MAG_W      = 30;
	localparam int DIG_W      = 3;
	localparam int DIV_DIGITS = MAG_W / DIG_W;
	localparam int DCNT_W     = $clog2(DIV_DIGITS);
	localparam int RX_W       = TICK_W + DIG_W;

	// Microcode addressing
	localparam int STEP_W = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd7;

	// Program step addresses
	localparam logic [STEP_W-1:0] STEP_INTERP   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DIV_LOAD = 4'd1;
	localparam logic [STEP_W-1:0] STEP_DIV      = 4'd2;
	localparam logic [STEP_W-1:0] STEP_SPEED    = 4'd3;
	localparam logic [STEP_W-1:0] STEP_MIX      = 4'd4;
	localparam logic [STEP_W-1:0] STEP_CLAMP    = 4'd5;
	localparam logic [STEP_W-1:0] STEP_OUT      = 4'd6;
	localparam logic [STEP_W-1:0] STEP_TICK     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_ERR      = 4'd8;
	localparam logic [STEP_W-1:0] STEP_PROP     = 4'd9;
	localparam logic [STEP_W-1:0] STEP_INTEG    = 4'd10;
	localparam logic [STEP_W-1:0] STEP_SUM      = 4'd11;
	localparam logic [STEP_W-1:0] STEP_LIMIT    = 4'd12;
	localparam logic [STEP_W-1:0] STEP_COMMIT   = 4'd13;

	typedef struct packed {
		logic                     upright_mode;
		logic signed [TGT_W-1:0]  target_speed;
		logic [ELIM_W-1:0]        error_limit;
		logic [GAIN_W-1:0]        gain_prop;
		logic [GAIN_W-1:0]        gain_integ;
		logic [LIM_W-1:0]         step_limit;
		logic [LIM_W-1:0]         dead_band;
		logic [LIM_W-1:0]         drive_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		upright_mode: 1'b1,
		target_speed: 13'sd0,
		error_limit:  12'd200,
		gain_prop:    16'd77,
		gain_integ:   16'd0,
		step_limit:   23'd10240,
		dead_band:    23'd0,
		drive_limit:  23'd17920
	};

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_SPEED,
		OP_MIX,
		OP_CLAMP,
		OP_OUT,
		OP_TICK,
		OP_ERR,
		OP_ESUM,
		OP_COMMIT
	} dp_op_t;

	typedef enum logic [1:0] {
		MUL_OFF,
		MUL_INTERP,
		MUL_PROP,
		MUL_INTEG
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_LIMIT
	} acc_op_t;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_LOOP,
		JMP_WAIT,
		JMP_SKIP,
		JMP_END
	} jump_t;

	typedef struct packed {
		dp_op_t              op;
		mul_sel_t            mul;
		acc_op_t             acc;
		jump_t               jmp;
		logic [STEP_W-1:0]   target;
	} ucode_word_t;

	typedef struct packed {
		logic div_last;
		logic loop_due;
		logic out_busy;
	} seq_status_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

endpackage

[sv/wslmm_ifs.sv]
// Channel interfaces: tick samples, motor commands and configuration writes.
interface wslmm_sample_if;
	import wslmm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [BAL_W-1:0]   balance_drive;
	logic signed [BAL_W-1:0]   steer_drive;
	logic signed [CNT_W-1:0]   left_count;
	logic signed [CNT_W-1:0]   right_count;
	logic                      in_transition;

	modport source (output valid, balance_drive, steer_drive, left_count, right_count,
		in_transition, input ready);
	modport sink (input valid, balance_drive, steer_drive, left_count, right_count,
		in_transition, output ready);
endinterface

interface wslmm_command_if;
	import wslmm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [DRV_W-1:0]   left_drive;
	logic signed [DRV_W-1:0]   right_drive;
	logic signed [BAL_W-1:0]   speed_drive;

	modport source (output valid, left_drive, right_drive, speed_drive, input ready);
	modport sink (input valid, left_drive, right_drive, speed_drive, output ready);
endinterface

interface wslmm_cfg_if;
	import wslmm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_IDX_W-1:0]      index;
	logic [CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/wheel_speed_loop_motor_mix_unit.sv]
// Top level of the wheel speed loop and motor mix block.
//
// Channel  Role    Transfer         Payload
// sample   sink    valid & ready    balance_drive, steer_drive, left_count, right_count,
//                                   in_transition
// command  source  valid & ready    left_drive, right_drive, speed_drive
// cfg      sink    valid (ready=1)  index, data
//
// The block takes the next sample only once the program for the last one has ended; the
// program runs the ten radix-8 digits of the interpolation divide, the mix and output
// steps and, on a tick that runs the speed loop, the speed loop steps as well.
// arst_n clears the sequencer, the result valid, the configuration registers and the
// tick counter, previous error, error sum and drive history; working registers have no reset.
// A result still waiting on command holds the program at its output step.
module wheel_speed_loop_motor_mix_unit #(
	parameter int unsigned PERIOD = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	wslmm_sample_if.sink     sample,
	wslmm_command_if.source  command,
	wslmm_cfg_if.sink        cfg
);
	import wslmm_pkg::*;

	cfg_t              cfg_q;
	ucode_word_t       cw;
	seq_status_t       status;
	logic [STEP_W-1:0] step;
	logic              idle;
	logic              run;
	logic              load;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_UPRIGHT_MODE: cfg_q.upright_mode <= cfg.data[0];
				REG_TARGET_SPEED: cfg_q.target_speed <= cfg.data[TGT_W-1:0];
				REG_ERROR_LIMIT:  cfg_q.error_limit  <= cfg.data[ELIM_W-1:0];
				REG_GAIN_PROP:    cfg_q.gain_prop    <= cfg.data[GAIN_W-1:0];
				REG_GAIN_INTEG:   cfg_q.gain_integ   <= cfg.data[GAIN_W-1:0];
				REG_STEP_LIMIT:   cfg_q.step_limit   <= cfg.data[LIM_W-1:0];
				REG_DEAD_BAND:    cfg_q.dead_band    <= cfg.data[LIM_W-1:0];
				REG_DRIVE_LIMIT:  cfg_q.drive_limit  <= cfg.data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready    = 1'b1;
	assign sample.ready = idle;
	assign load         = sample.valid && idle;

	wslmm_ucode u_ucode (
		.step (step),
		.cw   (cw)
	);

	wslmm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (load),
		.cw     (cw),
		.status (status),
		.idle   (idle),
		.run    (run),
		.step   (step)
	);

	wslmm_dp #(
		.PERIOD (PERIOD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.balance_drive (sample.balance_drive),
		.steer_drive   (sample.steer_drive),
		.left_count    (sample.left_count),
		.right_count   (sample.right_count),
		.in_transition (sample.in_transition),
		.cfg           (cfg_q),
		.cw            (cw),
		.run           (run),
		.out_ready     (command.ready),
		.status        (status),
		.out_valid     (command.valid),
		.left_drive    (command.left_drive),
		.right_drive   (command.right_drive),
		.speed_drive   (command.speed_drive)
	);

endmodule

[sv/wslmm_ucode.sv]
// Microcode ROM: one control word per program step.
module wslmm_ucode (
	input  logic [wslmm_pkg::STEP_W-1:0] step,
	output wslmm_pkg::ucode_word_t       cw
);
	import wslmm_pkg::*;

	always_comb begin
		cw = '{op: OP_NOP, mul: MUL_OFF, acc: ACC_HOLD, jmp: JMP_NEXT, target: STEP_INTERP};
		unique case (step)
			// interpolation product (new - old) * (tick + 1)
			STEP_INTERP:   cw.mul = MUL_INTERP;
			STEP_DIV_LOAD: cw.op = OP_DIV_LOAD;
			// one radix-8 digit per pass, loop until the last digit
			STEP_DIV: begin
				cw.op     = OP_DIV_STEP;
				cw.jmp    = JMP_LOOP;
				cw.target = STEP_DIV;
			end
			STEP_SPEED:    cw.op = OP_SPEED;
			STEP_MIX:      cw.op = OP_MIX;
			STEP_CLAMP:    cw.op = OP_CLAMP;
			// hold here while the previous result is still waiting
			STEP_OUT: begin
				cw.op  = OP_OUT;
				cw.jmp = JMP_WAIT;
			end
			// end the program unless the speed loop is due
			STEP_TICK: begin
				cw.op  = OP_TICK;
				cw.jmp = JMP_SKIP;
			end
			STEP_ERR:      cw.op = OP_ERR;
			STEP_PROP: begin
				cw.op  = OP_ESUM;
				cw.mul = MUL_PROP;
			end
			STEP_INTEG: begin
				cw.mul = MUL_INTEG;
				cw.acc = ACC_LOAD;
			end
			STEP_SUM:      cw.acc = ACC_ADD;
			STEP_LIMIT:    cw.acc = ACC_LIMIT;
			STEP_COMMIT: begin
				cw.op  = OP_COMMIT;
				cw.jmp = JMP_END;
			end
			default:       cw.jmp = JMP_END;
		endcase
	end

endmodule

[sv/wslmm_seq.sv]
// Program sequencer: step counter with conditional jumps and output stall.
module wslmm_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  wslmm_pkg::ucode_word_t       cw,
	input  wslmm_pkg::seq_status_t       status,
	output logic                         idle,
	output logic                         run,
	output logic [wslmm_pkg::STEP_W-1:0] step
);
	import wslmm_pkg::*;

	seq_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	// Hold state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			step_q  <= STEP_INTERP;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Advance, loop, wait or end according to the control word
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		run     = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_d = SEQ_RUN;
					step_d  = STEP_INTERP;
				end
			end
			SEQ_RUN: begin
				run = 1'b1;
				unique case (cw.jmp)
					JMP_NEXT: step_d = step_q + 1'b1;
					JMP_LOOP: step_d = status.div_last ? step_q + 1'b1 : cw.target;
					JMP_WAIT: begin
						if (status.out_busy) begin
							run = 1'b0;
						end else begin
							step_d = step_q + 1'b1;
						end
					end
					JMP_SKIP: begin
						if (status.loop_due) begin
							step_d = step_q + 1'b1;
						end else begin
							state_d = SEQ_IDLE;
						end
					end
					JMP_END: state_d = SEQ_IDLE;
					default: state_d = SEQ_IDLE;
				endcase
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	assign idle = (state_q == SEQ_IDLE);
	assign step = step_q;

endmodule

[sv/wslmm_dp.sv]
// Datapath: shared multiplier, radix-8 divider, mix and speed loop registers.
module wslmm_dp #(
	parameter int unsigned PERIOD = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [wslmm_pkg::BAL_W-1:0]  balance_drive,
	input  logic signed [wslmm_pkg::BAL_W-1:0]  steer_drive,
	input  logic signed [wslmm_pkg::CNT_W-1:0]  left_count,
	input  logic signed [wslmm_pkg::CNT_W-1:0]  right_count,
	input  logic                                in_transition,
	input  wslmm_pkg::cfg_t                     cfg,
	input  wslmm_pkg::ucode_word_t              cw,
	input  logic                                run,
	input  logic                                out_ready,
	output wslmm_pkg::seq_status_t              status,
	output logic                                out_valid,
	output logic signed [wslmm_pkg::DRV_W-1:0]  left_drive,
	output logic signed [wslmm_pkg::DRV_W-1:0]  right_drive,
	output logic signed [wslmm_pkg::BAL_W-1:0]  speed_drive
);
	import wslmm_pkg::*;

	localparam int TW1 = TICK_W + 1;
	localparam int MW  = BAL_W + 2;
	localparam int EW  = CNT_W + 2;
	localparam logic [TW1-1:0] PERIOD_X = TW1'(PERIOD);

	// captured tick
	logic signed [BAL_W-1:0]  bal_q, steer_q;
	logic signed [CNT_W-1:0]  lc_q, rc_q;
	logic                     trans_q;

	// loop state
	logic [TICK_W-1:0]        tick_q;
	logic signed [ERR_W-1:0]  prev_err_q, err_q;
	logic signed [ESUM_W-1:0] esum_q;
	logic signed [BAL_W-1:0]  old_q, new_q;

	// working registers
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic [MAG_W-1:0]         dvd_q, quo_q;
	logic [TICK_W-1:0]        rem_q;
	logic                     neg_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic signed [BAL_W-1:0]  speed_q;
	logic signed [MW-1:0]     mix_q;
	logic                     out_valid_q;
	logic signed [DRV_W-1:0]  left_q, right_q;
	logic signed [BAL_W-1:0]  speed_out_q;

	// combinational values
	logic                     mode;
	logic [TW1-1:0]           tick_inc;
	logic                     loop_due;
	logic signed [BAL_W:0]    diff;
	logic signed [ERR_W:0]    ediff;
	logic signed [MA_W-1:0]   ma;
	logic signed [MB_W-1:0]   mb;
	logic signed [PROD_W-1:0] mul_res, pmag;
	logic [RX_W-1:0]          rx, sub, rem_next;
	logic [DIG_W-1:0]         dig;
	logic signed [BAL_W:0]    qmag, qs, spd_sum, bal_x, spd_x, mix0;
	logic signed [MW-1:0]     m_ext, db_x, mix_d, dl_x, clamp_d, st_x, lsum, rsum;
	logic signed [DRV_W-1:0]  left_d, right_d;
	logic signed [CNT_W:0]    csum;
	logic signed [CNT_W-1:0]  avg;
	logic signed [EW-1:0]     e_raw, el_x, err_d;
	logic signed [ESUM_W:0]   es_sum;
	logic signed [ESUM_W-1:0] esum_d;
	logic signed [PROD_W-1:0] sl_x, acc_lim, new_x, cv;
	logic                     cv_fits;
	logic signed [BAL_W-1:0]  commit_d;

	assign mode = cfg.upright_mode;

	// Select multiplier operands and form the product
	always_comb begin
		tick_inc = {1'b0, tick_q} + TW1'(1);
		loop_due = (tick_inc >= PERIOD_X);
		diff     = {new_q[BAL_W-1], new_q} - {old_q[BAL_W-1], old_q};
		ediff    = {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};
		ma       = '0;
		mb       = '0;
		unique case (cw.mul)
			MUL_INTERP: begin
				ma = {{(MA_W-TW1){1'b0}}, tick_inc};
				mb = {{(MB_W-BAL_W-1){diff[BAL_W]}}, diff};
			end
			MUL_PROP: begin
				ma = {1'b0, cfg.gain_prop};
				mb = mode ? {{(MB_W-ERR_W){err_q[ERR_W-1]}}, err_q}
				          : {{(MB_W-ERR_W-1){ediff[ERR_W]}}, ediff};
			end
			MUL_INTEG: begin
				ma = {1'b0, cfg.gain_integ};
				mb = mode ? {esum_q[ESUM_W-1], esum_q}
				          : {{(MB_W-ERR_W){err_q[ERR_W-1]}}, err_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		mul_res = ma * mb;
	end

	// Pick the next quotient digit from the multiples of the period
	always_comb begin
		pmag = prod_q[PROD_W-1] ? -prod_q : prod_q;
		rx   = {rem_q, dvd_q[MAG_W-1 -: DIG_W]};
		dig  = '0;
		sub  = '0;
		for (int k = 1; k < (1 << DIG_W); k++) begin
			if (rx >= RX_W'(k * PERIOD)) begin
				dig = DIG_W'(k);
				sub = RX_W'(k * PERIOD);
			end
		end
		rem_next = rx - sub;
	end

	// Speed drive, mix, dead band, drive clamp and steering
	always_comb begin
		qmag    = {1'b0, quo_q[BAL_W-1:0]};
		qs      = neg_q ? -qmag : qmag;
		spd_sum = {old_q[BAL_W-1], old_q} + qs;

		bal_x = {bal_q[BAL_W-1], bal_q};
		spd_x = {speed_q[BAL_W-1], speed_q};
		if (trans_q) begin
			mix0 = bal_x;
		end else if (mode) begin
			mix0 = bal_x - spd_x;
		end else begin
			mix0 = bal_x + spd_x;
		end
		m_ext = {mix0[BAL_W], mix0};
		db_x  = {{(MW-LIM_W){1'b0}}, cfg.dead_band};
		if (mix0 > 0) begin
			mix_d = m_ext + db_x;
		end else if (mix0 < 0) begin
			mix_d = m_ext - db_x;
		end else begin
			mix_d = m_ext;
		end

		dl_x = {{(MW-LIM_W){1'b0}}, cfg.drive_limit};
		if (mix_q > dl_x) begin
			clamp_d = dl_x;
		end else if (mix_q < -dl_x) begin
			clamp_d = -dl_x;
		end else begin
			clamp_d = mix_q;
		end

		st_x = {{(MW-BAL_W){steer_q[BAL_W-1]}}, steer_q};
		lsum = mix_q - st_x;
		rsum = mix_q + st_x;
		left_d  = (lsum[MW-1] != lsum[MW-2]) ? {lsum[MW-1], {(DRV_W-1){~lsum[MW-1]}}}
		                                     : lsum[DRV_W-1:0];
		right_d = (rsum[MW-1] != rsum[MW-2]) ? {rsum[MW-1], {(DRV_W-1){~rsum[MW-1]}}}
		                                     : rsum[DRV_W-1:0];
	end

	// Speed error, error sum, step limit and result saturation
	always_comb begin
		csum  = {lc_q[CNT_W-1], lc_q} + {rc_q[CNT_W-1], rc_q};
		avg   = csum[CNT_W:1];
		e_raw = {{(EW-TGT_W){cfg.target_speed[TGT_W-1]}}, cfg.target_speed}
		      - {{(EW-CNT_W){avg[CNT_W-1]}}, avg};
		el_x  = {{(EW-ELIM_W){1'b0}}, cfg.error_limit};
		if (e_raw > el_x) begin
			err_d = el_x;
		end else if (e_raw < -el_x) begin
			err_d = -el_x;
		end else begin
			err_d = e_raw;
		end

		es_sum = {esum_q[ESUM_W-1], esum_q} + {{(ESUM_W-ERR_W+1){err_q[ERR_W-1]}}, err_q};
		esum_d = (es_sum[ESUM_W] != es_sum[ESUM_W-1])
		       ? {es_sum[ESUM_W], {(ESUM_W-1){~es_sum[ESUM_W]}}} : es_sum[ESUM_W-1:0];

		sl_x = {{(PROD_W-LIM_W){1'b0}}, cfg.step_limit};
		if (acc_q > sl_x) begin
			acc_lim = sl_x;
		end else if (acc_q < -sl_x) begin
			acc_lim = -sl_x;
		end else begin
			acc_lim = acc_q;
		end

		new_x    = {{(PROD_W-BAL_W){new_q[BAL_W-1]}}, new_q};
		cv       = mode ? acc_q : acc_q + new_x;
		cv_fits  = (&cv[PROD_W-1:BAL_W-1]) || ~(|cv[PROD_W-1:BAL_W-1]);
		commit_d = cv_fits ? cv[BAL_W-1:0] : {cv[PROD_W-1], {(BAL_W-1){~cv[PROD_W-1]}}};
	end

	// Loop state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			prev_err_q  <= '0;
			esum_q      <= '0;
			old_q       <= '0;
			new_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (run) begin
				unique case (cw.op)
					OP_OUT:  out_valid_q <= 1'b1;
					OP_TICK: tick_q <= loop_due ? '0 : tick_inc[TICK_W-1:0];
					OP_ESUM: begin
						if (mode) begin
							esum_q <= esum_d;
						end
					end
					OP_COMMIT: begin
						old_q      <= new_q;
						new_q      <= commit_d;
						prev_err_q <= err_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Working registers and captured tick
	always_ff @(posedge clk) begin
		if (load) begin
			bal_q   <= balance_drive;
			steer_q <= steer_drive;
			lc_q    <= left_count;
			rc_q    <= right_count;
			trans_q <= in_transition;
		end
		if (run) begin
			if (cw.mul != MUL_OFF) begin
				prod_q <= mul_res;
			end
			unique case (cw.acc)
				ACC_LOAD:  acc_q <= prod_q;
				ACC_ADD:   acc_q <= acc_q + prod_q;
				ACC_LIMIT: begin
					if (!mode) begin
						acc_q <= acc_lim;
					end
				end
				default: begin
				end
			endcase
			unique case (cw.op)
				OP_DIV_LOAD: begin
					dvd_q  <= pmag[MAG_W-1:0];
					neg_q  <= prod_q[PROD_W-1];
					rem_q  <= '0;
					quo_q  <= '0;
					dcnt_q <= DCNT_W'(DIV_DIGITS - 1);
				end
				OP_DIV_STEP: begin
					rem_q  <= rem_next[TICK_W-1:0];
					quo_q  <= {quo_q[MAG_W-DIG_W-1:0], dig};
					dvd_q  <= {dvd_q[MAG_W-DIG_W-1:0], {DIG_W{1'b0}}};
					dcnt_q <= dcnt_q - 1'b1;
				end
				OP_SPEED: speed_q <= spd_sum[BAL_W-1:0];
				OP_MIX:   mix_q <= mix_d;
				OP_CLAMP: mix_q <= clamp_d;
				OP_OUT: begin
					left_q      <= left_d;
					right_q     <= right_d;
					speed_out_q <= speed_q;
				end
				OP_ERR:   err_q <= err_d[ERR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign status.div_last = (dcnt_q == '0);
	assign status.loop_due = loop_due;
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign speed_drive = speed_out_q;

endmodule

[sv/wslmm_chk.sv]
// Port checker for the wheel speed loop and motor mix block, with its bind.
module wslmm_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [wslmm_pkg::DRV_W-1:0]  left_drive,
	input logic signed [wslmm_pkg::DRV_W-1:0]  right_drive,
	input logic signed [wslmm_pkg::BAL_W-1:0]  speed_drive
);
	import wslmm_pkg::*;

	logic       in_xfer, out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Count ticks taken whose result has not been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive)
			&& $stable(right_drive) && $stable(speed_drive))
		else $error("command payload changed while stalled");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("command valid dropped without a transfer");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("sample ready stayed high right after a transfer");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != 2'd3) && (!out_valid || pend_q == 2'd1 || pend_q == 2'd2))
		else $error("results out of step with taken ticks");

endmodule

bind wheel_speed_loop_motor_mix_unit wslmm_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (command.valid),
	.out_ready   (command.ready),
	.left_drive  (command.left_drive),
	.right_drive (command.right_drive),
	.speed_drive (command.speed_drive)
);
